>>> rtl/pptl_pkg.sv
// Shared types and constants for the positional PID torque loop.
// Used by every RTL file of the block; depends on nothing else.
package pptl_pkg;

    localparam int POS_W    = 32;
    localparam int ERR_W    = POS_W + 1;
    localparam int DIFF_W   = POS_W + 2;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int RUN_W    = 16;
    localparam int INTEG_W  = 64;
    localparam int TORQUE_W = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic signed [GAIN_W-1:0] KP_RESET    = 16'sd256;
    localparam logic signed [GAIN_W-1:0] KI_RESET    = 16'sd0;
    localparam logic signed [GAIN_W-1:0] KD_RESET    = 16'sd5120;
    localparam logic [LIMIT_W-1:0]       LIMIT_RESET = 15'd3000;
    localparam logic [RUN_W-1:0]         RUN_RESET   = 16'd1000;

    localparam logic [2:0] REG_KP    = 3'd0;
    localparam logic [2:0] REG_KI    = 3'd1;
    localparam logic [2:0] REG_KD    = 3'd2;
    localparam logic [2:0] REG_LIMIT = 3'd3;
    localparam logic [2:0] REG_RUN   = 3'd4;

    typedef struct packed {
        logic signed [POS_W-1:0] target_position;
        logic signed [POS_W-1:0] actual_position;
    } t_in;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] torque_command;
        logic                       run_finished;
    } t_out;

    typedef struct packed {
        logic signed [GAIN_W-1:0] proportional_gain;
        logic signed [GAIN_W-1:0] integral_gain;
        logic signed [GAIN_W-1:0] derivative_gain;
        logic [LIMIT_W-1:0]       output_limit;
        logic [RUN_W-1:0]         run_length;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DIFF_W-1:0]  diff;
        logic signed [INTEG_W-1:0] integral;
        logic                      done;
    } t_s1;

endpackage

>>> rtl/pptl_cfg_regs.sv
// APB-style configuration registers for the positional PID torque loop.
// Depends on pptl_pkg for the register map and the configuration struct.
module pptl_cfg_regs import pptl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.proportional_gain <= KP_RESET;
            r_cfg.integral_gain     <= KI_RESET;
            r_cfg.derivative_gain   <= KD_RESET;
            r_cfg.output_limit      <= LIMIT_RESET;
            r_cfg.run_length        <= RUN_RESET;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_KP:    r_cfg.proportional_gain <= pwdata[GAIN_W-1:0];
                REG_KI:    r_cfg.integral_gain     <= pwdata[GAIN_W-1:0];
                REG_KD:    r_cfg.derivative_gain   <= pwdata[GAIN_W-1:0];
                REG_LIMIT: r_cfg.output_limit      <= pwdata[LIMIT_W-1:0];
                REG_RUN:   r_cfg.run_length        <= pwdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_KP:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.proportional_gain};
            REG_KI:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.integral_gain};
            REG_KD:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.derivative_gain};
            REG_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, r_cfg.output_limit};
            REG_RUN:   prdata = {{(DATA_W-RUN_W){1'b0}}, r_cfg.run_length};
            default:   prdata = '0;
        endcase
    end

endmodule

>>> rtl/pptl_state.sv
// Error stage: forms the error and its difference, updates the saturating
// integral and the tick counter. Depends on pptl_pkg.
module pptl_state import pptl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_in  i_data,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_s1  o_s1
);

    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic [RUN_W-1:0]          r_tick;
    logic                      r_valid;
    t_s1                       r_s1;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] n_integral;
    logic [RUN_W:0]            tick_inc;
    logic                      n_done;

    always_comb begin
        n_err  = ERR_W'(i_data.target_position) - ERR_W'(i_data.actual_position);
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_prev_err);
        integ_sum = (INTEG_W+1)'(r_integral) + (INTEG_W+1)'(n_err);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            n_integral = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_integral = integ_sum[INTEG_W-1:0];
        end
        tick_inc = {1'b0, r_tick} + (RUN_W+1)'(1);
        n_done   = tick_inc >= {1'b0, i_cfg.run_length};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
            r_tick     <= '0;
            r_valid    <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_integral <= n_done ? '0 : n_integral;
                r_prev_err <= n_done ? '0 : n_err;
                r_tick     <= n_done ? '0 : tick_inc[RUN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_s1.err      <= n_err;
            r_s1.diff     <= n_diff;
            r_s1.integral <= n_integral;
            r_s1.done     <= n_done;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

>>> rtl/pptl_datapath.sv
// Gain stages: partial products, their sum, the fraction shift and the clamp.
// Depends on pptl_pkg; fed by pptl_state.
module pptl_datapath import pptl_pkg::*; #(
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_s1  i_s1,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_out o_data
);

    localparam int HALF_W = INTEG_W / 2;
    localparam int KP_W   = GAIN_W + ERR_W;
    localparam int KD_W   = GAIN_W + DIFF_W;
    localparam int IH_W   = GAIN_W + HALF_W;
    localparam int IL_W   = GAIN_W + HALF_W + 1;
    localparam int SUM_W  = GAIN_W + INTEG_W + 2;

    logic signed [KP_W-1:0]  r_p_kp;
    logic signed [KD_W-1:0]  r_p_kd;
    logic signed [IH_W-1:0]  r_p_ih;
    logic signed [IL_W-1:0]  r_p_il;
    logic                    r_p_done;
    logic                    r_p_valid;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_sum_done;
    logic                    r_sum_valid;
    t_out                    r_out;
    logic                    r_out_valid;

    logic signed [KP_W-1:0]  n_p_kp;
    logic signed [KD_W-1:0]  n_p_kd;
    logic signed [IH_W-1:0]  n_p_ih;
    logic signed [IL_W-1:0]  n_p_il;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] shifted;
    logic signed [SUM_W-1:0] lim_pos;
    logic signed [SUM_W-1:0] lim_neg;
    logic signed [SUM_W-1:0] clamped;

    always_comb begin
        n_p_kp = KP_W'(i_cfg.proportional_gain) * KP_W'(i_s1.err);
        n_p_kd = KD_W'(i_cfg.derivative_gain) * KD_W'(i_s1.diff);
        n_p_ih = IH_W'(i_cfg.integral_gain)
               * IH_W'($signed(i_s1.integral[INTEG_W-1:HALF_W]));
        n_p_il = IL_W'(i_cfg.integral_gain)
               * IL_W'($signed({1'b0, i_s1.integral[HALF_W-1:0]}));
        n_sum  = SUM_W'(r_p_kp) + SUM_W'(r_p_kd) + (SUM_W'(r_p_ih) <<< HALF_W)
               + SUM_W'(r_p_il);
        shifted = r_sum >>> GAIN_FRACTION_BITS;
        lim_pos = SUM_W'($signed({1'b0, i_cfg.output_limit}));
        lim_neg = -lim_pos;
        if (shifted > lim_pos) begin
            clamped = lim_pos;
        end else if (shifted < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_sum_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid   <= i_valid;
            r_sum_valid <= r_p_valid;
            r_out_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_kp               <= n_p_kp;
            r_p_kd               <= n_p_kd;
            r_p_ih               <= n_p_ih;
            r_p_il               <= n_p_il;
            r_p_done             <= i_s1.done;
            r_sum                <= n_sum;
            r_sum_done           <= r_p_done;
            r_out.torque_command <= clamped[TORQUE_W-1:0];
            r_out.run_finished   <= r_sum_done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> rtl/positional_pid_torque_loop.sv
// Positional PID torque loop with symmetric output clamp, top level.
// Depends on pptl_pkg, pptl_cfg_regs, pptl_state and pptl_datapath.
//
// Each request on the input channel is one control tick carrying a target and
// an actual position; each tick yields exactly one request on the output
// channel with the clamped torque command and the end-of-run flag.
// Both channels use valid/ready. Gains, output limit and run length are
// written over the APB-style port while the loop is idle.
// Ticks pass the input, error, product, sum and output registers, one tick per
// cycle unless the receiver stalls; the integral update closes in the error
// stage, and the integral gain product is split into two 16x32 halves.
// When the receiver stalls, the whole pipeline holds and one more input
// request is taken into a skid register before the input ready drops, so
// ready does not depend combinationally on the output side.
// Synchronous reset restores the default gains, limit 3000 and run length
// 1000, clears the integral, previous error and tick counter, and empties
// the pipeline.
module positional_pid_torque_loop import pptl_pkg::*; #(
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    t_s1  s1;
    logic s1_valid;
    logic en;
    logic in_take;

    logic r_skid_valid;
    t_in  r_skid_data;
    logic r_s0_valid;
    t_in  r_s0_data;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_skid_valid;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_s0_valid   <= 1'b0;
        end else if (en) begin
            r_s0_valid   <= r_skid_valid || in_take;
            r_skid_valid <= 1'b0;
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_data <= r_skid_valid ? r_skid_data : i_in_data;
        end else if (in_take) begin
            r_skid_data <= i_in_data;
        end
    end

    pptl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pptl_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_data  (r_s0_data),
        .i_cfg   (cfg),
        .o_valid (s1_valid),
        .o_s1    (s1)
    );

    pptl_datapath #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .i_cfg   (cfg),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_torque_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ($signed(o_out_data.torque_command) <= $signed({1'b0, cfg.output_limit})) &&
            ($signed(o_out_data.torque_command) >= -$signed({1'b0, cfg.output_limit})))
        else $error("torque command outside the output limit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s0_valid) && $stable(s1_valid) && $stable(o_out_valid))
        else $error("pipeline moved during an output stall");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(!en))
        else $error("skid register filled while the pipeline was advancing");

endmodule
